[design/rc_servo_frame_receiver_top_macros.svh]
// ----------------------------------------------------------------------------
// rc servo frame receiver assertion macros
// shared concurrent check forms for the receiver modules
// ----------------------------------------------------------------------------
`ifndef RC_SERVO_FRAME_RECEIVER_TOP_MACROS_SVH
`define RC_SERVO_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication check
`define RSFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication check
`define RSFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rsfr_pkg.sv]
// ----------------------------------------------------------------------------
// rsfr_pkg
// shared types and constants of the rc servo frame receiver
// ----------------------------------------------------------------------------
package rsfr_pkg;

   localparam int CHANNELS     = 14;
   localparam int STORE_DEPTH  = 32;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
   localparam int CHAN_IDX_W   = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_OVERHEAD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CODE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_VALUE       = 3'd5;

   // register reset values
   localparam logic [7:0]  GAP_TICKS_RST        = 8'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd1000;
   localparam logic [5:0]  MAX_FRAME_LENGTH_RST = 6'd32;
   localparam logic [3:0]  FRAME_OVERHEAD_RST   = 4'd3;
   localparam logic [7:0]  COMMAND_CODE_RST     = 8'd64;
   localparam logic [15:0] FILL_VALUE_RST       = 16'd1500;

   localparam logic [15:0] CHECK_SEED = 16'hFFFF;

   // input item kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [CHAN_IDX_W-1:0] channel_index;
      logic [15:0]           channel_value;
      logic                  link_lost;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  gap_ticks;
      logic [15:0] timeout_ticks;
      logic [5:0]  max_frame_length;
      logic [3:0]  frame_overhead;
      logic [7:0]  command_code;
      logic [15:0] fill_value;
   } cfg_type;

   // burst queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
      logic head_lost;
   } queue_status_type;

   // back part status and payload store read address
   typedef struct packed {
      logic                    busy;
      logic [STORE_ADDR_W-1:0] rd_addr;
   } back_status_type;

endpackage

[design/rsfr_front.sv]
// ----------------------------------------------------------------------------
// rsfr_front
// accepts bytes and ticks, parses frames, keeps the payload store and timers
// ----------------------------------------------------------------------------
module rsfr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rsfr_pkg::req_type                    req_data,
   input  rsfr_pkg::cfg_type                    cfg,
   input  rsfr_pkg::queue_status_type           q_status,
   input  rsfr_pkg::back_status_type            back_status,
   output logic                                 push,
   output logic                                 push_lost,
   output logic [7:0]                           rd_data
);

   typedef enum logic [2:0] {
      PH_DISCARD,
      PH_LENGTH,
      PH_DATA,
      PH_CHKL,
      PH_CHKH
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [5:0]  count_ff, count_in, count_inc;
   logic [5:0]  target_ff, target_in;
   logic [15:0] check_ff, check_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  idle_ff, idle_in;
   logic [15:0] since_ff, since_in;
   logic        link_ff, link_in;
   logic [7:0]  store_ff [rsfr_pkg::STORE_DEPTH];
   logic        store_we;
   logic [7:0]  len_diff;
   logic [7:0]  v;
   logic        accept;

   // ticks wait only for queue room, bytes wait until the burst is drained
   always_comb begin
      if (req_data.func == rsfr_pkg::FUNC_TICK) begin
         req_stall = q_status.full;
      end else begin
         req_stall = q_status.not_empty || back_status.busy;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign v         = req_data.byte_value;
   assign len_diff  = v - {4'd0, cfg.frame_overhead};
   assign count_inc = count_ff + 6'd1;
   assign rd_data   = store_ff[back_status.rd_addr];

   // next state of the parser and timers
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      target_in = target_ff;
      check_in  = check_ff;
      low_in    = low_ff;
      idle_in   = idle_ff;
      since_in  = since_ff;
      link_in   = link_ff;
      store_we  = 1'b0;
      push      = 1'b0;
      push_lost = 1'b0;
      phase_eff = (idle_ff >= cfg.gap_ticks) ? PH_LENGTH : phase_ff;
      if (accept) begin
         if (req_data.func == rsfr_pkg::FUNC_TICK) begin
            if (idle_ff != 8'hFF) begin
               idle_in = idle_ff + 8'd1;
            end
            if (since_ff != 16'hFFFF) begin
               since_in = since_ff + 16'd1;
            end
            // link loss once per receiving span
            if (link_ff && since_ff >= cfg.timeout_ticks) begin
               link_in   = 1'b0;
               push      = 1'b1;
               push_lost = 1'b1;
            end
         end else begin
            idle_in = 8'd0;
            unique case (phase_eff)
               PH_LENGTH: begin
                  if (v <= {2'd0, cfg.max_frame_length} &&
                      v >= {4'd0, cfg.frame_overhead} + 8'd1) begin
                     count_in  = 6'd0;
                     target_in = len_diff[5:0];
                     check_in  = rsfr_pkg::CHECK_SEED - {8'd0, v};
                     phase_in  = PH_DATA;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
               PH_DATA: begin
                  store_we = count_ff < 6'(rsfr_pkg::STORE_DEPTH);
                  check_in = check_ff - {8'd0, v};
                  count_in = count_inc;
                  if (count_inc == target_ff) begin
                     phase_in = PH_CHKL;
                  end
               end
               PH_CHKL: begin
                  low_in   = v;
                  phase_in = PH_CHKH;
               end
               PH_CHKH: begin
                  // good frame: checksum and command byte both match
                  if (check_ff == {v, low_ff} && store_ff[0] == cfg.command_code) begin
                     push     = 1'b1;
                     since_in = 16'd0;
                     link_in  = 1'b1;
                  end
                  phase_in = PH_DISCARD;
               end
               default: begin
                  phase_in = PH_DISCARD;
               end
            endcase
         end
      end
   end

   // parser state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DISCARD;
         count_ff  <= 6'd0;
         target_ff <= 6'd0;
         check_ff  <= 16'd0;
         low_ff    <= 8'd0;
         idle_ff   <= 8'd0;
         since_ff  <= 16'd0;
         link_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         check_ff  <= check_in;
         low_ff    <= low_in;
         idle_ff   <= idle_in;
         since_ff  <= since_in;
         link_ff   <= link_in;
      end
   end

   // payload store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rsfr_pkg::STORE_DEPTH; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else if (store_we) begin
         store_ff[count_ff[rsfr_pkg::STORE_ADDR_W-1:0]] <= v;
      end
   end

endmodule

[design/rsfr_queue.sv]
// ----------------------------------------------------------------------------
// rsfr_queue
// short queue of pending bursts between front and back
// ----------------------------------------------------------------------------
`include "rc_servo_frame_receiver_top_macros.svh"

module rsfr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       push_lost,
   input  logic                       pop,
   output rsfr_pkg::queue_status_type q_status
);

   localparam int PW = rsfr_pkg::QUEUE_PTR_W;
   localparam int CW = rsfr_pkg::QUEUE_CNT_W;

   logic          entry_ff [rsfr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   // pointer and fill count update, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // burst kind storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_lost;
      end
   end

   assign q_status.full      = count_ff == CW'(rsfr_pkg::QUEUE_DEPTH);
   assign q_status.not_empty = count_ff != '0;
   assign q_status.head_lost = entry_ff[rd_ptr_ff];

   `RSFR_ASSERT_NOW(a_no_push_full, clock, reset, push, count_ff != CW'(rsfr_pkg::QUEUE_DEPTH), "burst pushed into full queue")
   `RSFR_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, count_ff != '0, "burst popped from empty queue")
   `RSFR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(rsfr_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

[design/rsfr_back.sv]
// ----------------------------------------------------------------------------
// rsfr_back
// plays out one burst of channel results from the store or the fill value
// ----------------------------------------------------------------------------
`include "rc_servo_frame_receiver_top_macros.svh"

module rsfr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  rsfr_pkg::queue_status_type       q_status,
   output logic                             pop,
   output rsfr_pkg::back_status_type        back_status,
   input  logic [7:0]                       rd_data,
   input  logic [15:0]                      fill_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rsfr_pkg::rsp_type                rsp_data
);

   localparam int AW = rsfr_pkg::STORE_ADDR_W;
   localparam int IW = rsfr_pkg::CHAN_IDX_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(rsfr_pkg::CHANNELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_LO,
      ST_READ_HI,
      ST_SEND
   } state_type;

   state_type         state_ff;
   logic [IW-1:0]     index_ff;
   logic [IW-1:0]     index_inc;
   logic              lost_ff;
   logic [7:0]        low_ff;
   rsfr_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic [AW-1:0]     base_addr;
   logic              done;

   // channel i sits in store bytes 2i+1 and 2i+2
   assign base_addr              = AW'({index_ff, 1'b0});
   assign back_status.rd_addr    = (state_ff == ST_READ_HI) ? base_addr + AW'(2)
                                                            : base_addr + AW'(1);
   assign back_status.busy       = state_ff != ST_IDLE;
   assign pop                    = (state_ff == ST_IDLE) && q_status.not_empty;
   assign index_inc              = index_ff + IW'(1);
   assign done                   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data               = rsp_ff;

   // burst sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
         lost_ff      <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_status.not_empty) begin
                  index_ff <= '0;
                  lost_ff  <= q_status.head_lost;
                  if (q_status.head_lost) begin
                     rsp_ff.channel_index <= '0;
                     rsp_ff.channel_value <= fill_value;
                     rsp_ff.link_lost     <= 1'b1;
                     rsp_ff.last          <= LAST_IDX == '0;
                     rsp_valid_ff         <= 1'b1;
                     state_ff             <= ST_SEND;
                  end else begin
                     state_ff <= ST_READ_LO;
                  end
               end
            end
            ST_READ_LO: begin
               low_ff   <= rd_data;
               state_ff <= ST_READ_HI;
            end
            ST_READ_HI: begin
               rsp_ff.channel_index <= index_ff;
               rsp_ff.channel_value <= {rd_data, low_ff};
               rsp_ff.link_lost     <= 1'b0;
               rsp_ff.last          <= index_ff == LAST_IDX;
               rsp_valid_ff         <= 1'b1;
               state_ff             <= ST_SEND;
            end
            ST_SEND: begin
               if (done) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_ff.last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     index_ff <= index_inc;
                     if (lost_ff) begin
                        rsp_ff.channel_index <= index_inc;
                        rsp_ff.last          <= index_inc == LAST_IDX;
                        rsp_valid_ff         <= 1'b1;
                     end else begin
                        state_ff <= ST_READ_LO;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `RSFR_ASSERT_NOW(a_valid_in_send, clock, reset, rsp_valid_ff, state_ff == ST_SEND, "result shown outside send state")
   `RSFR_ASSERT_NEXT(a_last_to_idle, clock, reset, done && rsp_ff.last, state_ff == ST_IDLE && !rsp_valid_ff, "burst did not end after final transfer")
   `RSFR_ASSERT_NEXT(a_index_step, clock, reset, done && !rsp_ff.last, index_ff == $past(index_inc), "channel index did not advance")

endmodule

[design/rc_servo_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// rc_servo_frame_receiver_top
// receiver for length-prefixed, checksummed rc channel frames
// ----------------------------------------------------------------------------
// Input channel req_*: one transfer is a received byte or a one millisecond
// tick. An idle gap of gap_ticks opens a frame; a good frame (checksum and
// command byte match) yields a burst of 14 channel results on rsp_*.
// A link silent for more than timeout_ticks yields one burst of fill values
// with link_lost set. last marks the final channel of each burst.
// The parser takes a new byte or tick whenever req_stall is low. A frame
// burst reads each channel as two store bytes through the single store
// read port, low byte then high byte, and then shows it in the output
// register; a fill burst gives one result per cycle while rsp_stall is low.
// A two-entry burst queue sits between the parser and the burst sequencer.
// Bytes are held off while a burst is queued or playing, since they would
// overwrite the store it reads; ticks are held off only when the queue is
// full. A stalled rsp side holds the current result and stops the sequencer.
// Reset (synchronous) restores register defaults, clears the store, the
// parser, the timers and the queue; the block accepts transfers right after.
// csr_*: one write per cycle with csr_we, no read-back; write only when idle.
// ----------------------------------------------------------------------------
module rc_servo_frame_receiver_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rsfr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rsfr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [rsfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rsfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rsfr_pkg::cfg_type          cfg_ff;
   rsfr_pkg::queue_status_type q_status;
   rsfr_pkg::back_status_type  back_status;
   logic                       push;
   logic                       push_lost;
   logic                       pop;
   logic [7:0]                 rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_ticks        <= rsfr_pkg::GAP_TICKS_RST;
         cfg_ff.timeout_ticks    <= rsfr_pkg::TIMEOUT_TICKS_RST;
         cfg_ff.max_frame_length <= rsfr_pkg::MAX_FRAME_LENGTH_RST;
         cfg_ff.frame_overhead   <= rsfr_pkg::FRAME_OVERHEAD_RST;
         cfg_ff.command_code     <= rsfr_pkg::COMMAND_CODE_RST;
         cfg_ff.fill_value       <= rsfr_pkg::FILL_VALUE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rsfr_pkg::CSR_GAP_TICKS:        cfg_ff.gap_ticks        <= csr_wdata[7:0];
            rsfr_pkg::CSR_TIMEOUT_TICKS:    cfg_ff.timeout_ticks    <= csr_wdata[15:0];
            rsfr_pkg::CSR_MAX_FRAME_LENGTH: cfg_ff.max_frame_length <= csr_wdata[5:0];
            rsfr_pkg::CSR_FRAME_OVERHEAD:   cfg_ff.frame_overhead   <= csr_wdata[3:0];
            rsfr_pkg::CSR_COMMAND_CODE:     cfg_ff.command_code     <= csr_wdata[7:0];
            rsfr_pkg::CSR_FILL_VALUE:       cfg_ff.fill_value       <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // parser, store and timers
   rsfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .back_status (back_status),
      .push        (push),
      .push_lost   (push_lost),
      .rd_data     (rd_data)
   );

   // pending bursts
   rsfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_lost (push_lost),
      .pop       (pop),
      .q_status  (q_status)
   );

   // burst sequencer and result register
   rsfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop         (pop),
      .back_status (back_status),
      .rd_data     (rd_data),
      .fill_value  (cfg_ff.fill_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
